// ----- hdl/pal_pkg.sv -----
// types and constants shared by the positional array list
package pal_pkg;

   localparam int DATA_W  = 32;
   localparam int POS_W   = 8;
   localparam int KIND_W  = 2;
   localparam int STAT_W  = 2;
   localparam int TOTAL_W = 8;

   typedef enum logic [KIND_W-1:0] {
      OP_INSERT = 2'd0,
      OP_APPEND = 2'd1,
      OP_DELETE = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK      = 2'd0,
      ST_BAD_POS = 2'd1,
      ST_OVERFLOW = 2'd2,
      ST_SKIPPED = 2'd3
   } status_type;

   // commands broadcast to every cell of the row
   typedef struct packed {
      logic ins;    // open a slot at pos and write value there
      logic del;    // close the slot at pos
      logic load;   // cell at pos puts its word on the read bus
      logic walk;   // read bus moves one cell toward the head
   } cell_ctl_type;

endpackage

// ----- hdl/pal_req_if.sv -----
// operation channel of the positional array list
interface pal_req_if;
   import pal_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        kind;
   logic [POS_W-1:0]         position;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, kind, position, value, input ready);
   modport sink   (input valid, kind, position, value, output ready);
endinterface

// result channel of the positional array list
interface pal_rsp_if;
   import pal_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] data_out;
   logic [STAT_W-1:0]        status;
   logic [TOTAL_W-1:0]       entry_total;
   logic                     list_empty;
   logic                     list_full;

   modport source (output valid, data_out, status, entry_total, list_empty, list_full,
                   input ready);
   modport sink   (input valid, data_out, status, entry_total, list_empty, list_full,
                   output ready);
endinterface

// ----- hdl/pal_cell.sv -----
// one list cell: a stored word plus one stage of the read bus
module pal_cell #(
   parameter int INDEX = 0,
   parameter int PW    = 8
) (
   input  logic                              clock,
   input  pal_pkg::cell_ctl_type             ctl,
   input  logic [PW-1:0]                     pos,
   input  logic signed [pal_pkg::DATA_W-1:0] value,
   input  logic signed [pal_pkg::DATA_W-1:0] up_word,
   input  logic signed [pal_pkg::DATA_W-1:0] down_word,
   input  logic signed [pal_pkg::DATA_W-1:0] bus_next,
   output logic signed [pal_pkg::DATA_W-1:0] word,
   output logic signed [pal_pkg::DATA_W-1:0] bus
);
   import pal_pkg::*;

   localparam logic [PW-1:0] IDX = PW'(INDEX);

   logic signed [DATA_W-1:0] word_ff, word_in;
   logic signed [DATA_W-1:0] bus_ff, bus_in;

   always_comb begin
      priority if (ctl.ins && (IDX > pos)) begin
         word_in = up_word;
      end else if (ctl.ins && (IDX == pos)) begin
         word_in = value;
      end else if (ctl.del && (IDX >= pos)) begin
         word_in = down_word;
      end else begin
         word_in = word_ff;
      end
   end

   always_comb begin
      priority if (ctl.load) begin
         bus_in = (IDX == pos) ? word_ff : '0;
      end else if (ctl.walk) begin
         bus_in = bus_next;
      end else begin
         bus_in = bus_ff;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      bus_ff  <= bus_in;
   end

   assign word = word_ff;
   assign bus  = bus_ff;

endmodule

// ----- hdl/positional_array_list_unit.sv -----
// top level of the positional array list: control, count and the row of cells
//
//   channel  dir  handshake       payload
//   req_ch   in   valid / ready   kind, position, value
//   rsp_ch   out  valid / ready   data_out, status, entry_total, list_empty, list_full
//
// one item at a time; insert, append and failed operations answer in the cycle after accept
// read and delete at position p answer once the word has walked
//   down the read bus through the row of cells to the head, one cell per cycle
// the shift for insert and delete happens in all cells at once on the accept edge
// reset clears the count and control only; stored words are not cleared
// a result held by a stalled rsp_ch blocks the next item until it is taken
module positional_array_list_unit #(
   parameter int CAPACITY = 128
) (
   input  logic      clock,
   input  logic      reset,
   pal_req_if.sink   req_ch,
   pal_rsp_if.source rsp_ch
);
   import pal_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int PW    = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_WALK = 3'b010,
      S_RESP = 3'b100
   } state_type;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         walk_ff, walk_in;
   logic signed [DATA_W-1:0] data_ff, data_in;
   status_type               status_ff, status_in;

   logic                     accept;
   logic [PW-1:0]            pos_ext, count_ext, cell_pos;
   logic                     room, ins_ok, rd_ok;
   cell_ctl_type             ctl;

   logic signed [DATA_W-1:0] word_w [CAPACITY];
   logic signed [DATA_W-1:0] bus_w  [CAPACITY];

   assign accept    = req_ch.valid && req_ch.ready;
   assign pos_ext   = PW'(req_ch.position);
   assign count_ext = PW'(count_ff);
   assign room      = count_ff < CNT_W'(CAPACITY);
   assign ins_ok    = room && (pos_ext <= count_ext);
   assign rd_ok     = pos_ext < count_ext;

   // append is an insert at the current end
   assign cell_pos = (req_ch.kind == OP_APPEND) ? count_ext : pos_ext;

   always_comb begin
      ctl      = '0;
      ctl.ins  = accept && (((req_ch.kind == OP_INSERT) && ins_ok) ||
                            ((req_ch.kind == OP_APPEND) && room));
      ctl.del  = accept && (req_ch.kind == OP_DELETE) && rd_ok;
      ctl.load = accept && ((req_ch.kind == OP_DELETE) || (req_ch.kind == OP_READ)) && rd_ok;
      ctl.walk = (state_ff == S_WALK) && (walk_ff != '0);
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] up_word, down_word, bus_next;

      if (i == 0) begin : g_head
         assign up_word = '0;
      end else begin : g_up
         assign up_word = word_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign down_word = word_w[i];
         assign bus_next  = '0;
      end else begin : g_down
         assign down_word = word_w[i+1];
         assign bus_next  = bus_w[i+1];
      end

      pal_cell #(
         .INDEX (i),
         .PW    (PW)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .pos       (cell_pos),
         .value     (req_ch.value),
         .up_word   (up_word),
         .down_word (down_word),
         .bus_next  (bus_next),
         .word      (word_w[i]),
         .bus       (bus_w[i])
      );
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      walk_in   = walk_ff;
      data_in   = data_ff;
      status_in = status_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               data_in   = '0;
               status_in = ST_OK;
               state_in  = S_RESP;
               unique case (op_type'(req_ch.kind))
                  OP_INSERT: begin
                     if (ins_ok) begin
                        count_in = count_ff + CNT_W'(1);
                     end else begin
                        status_in = ST_SKIPPED;
                     end
                  end
                  OP_APPEND: begin
                     if (room) begin
                        count_in = count_ff + CNT_W'(1);
                     end else begin
                        status_in = ST_OVERFLOW;
                     end
                  end
                  OP_DELETE, OP_READ: begin
                     if (rd_ok) begin
                        if (req_ch.kind == OP_DELETE) begin
                           count_in = count_ff - CNT_W'(1);
                        end
                        walk_in  = pos_ext[IDX_W-1:0];
                        state_in = S_WALK;
                     end else begin
                        status_in = ST_BAD_POS;
                     end
                  end
                  default: status_in = ST_OK;
               endcase
            end
         end
         S_WALK: begin
            if (walk_ff == '0) begin
               data_in  = bus_w[0];
               state_in = S_RESP;
            end else begin
               walk_in = walk_ff - IDX_W'(1);
            end
         end
         S_RESP: begin
            if (rsp_ch.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      walk_ff   <= walk_in;
      data_ff   <= data_in;
      status_ff <= status_in;
   end

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = (state_ff == S_RESP);
   assign rsp_ch.data_out    = data_ff;
   assign rsp_ch.status      = status_ff;
   assign rsp_ch.entry_total = count_ext[TOTAL_W-1:0];
   assign rsp_ch.list_empty  = (count_ff == '0);
   assign rsp_ch.list_full   = (count_ff == CNT_W'(CAPACITY));

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count beyond capacity");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      accept && (req_ch.kind == OP_APPEND) && room |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("accepted append did not grow the list");

   a_delete_shrinks: assert property (@(posedge clock) disable iff (reset)
      accept && (req_ch.kind == OP_DELETE) && rd_ok |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("accepted delete did not shrink the list");

   a_bad_pos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.status == ST_BAD_POS) |-> rsp_ch.data_out == '0)
      else $error("bad position result carries data");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("new item taken while a result is pending");

endmodule
